// ===== src/bf_pkg.sv =====
// Shared constants and types for the 3x3 zero-padded box filter.
// No dependencies; bf_if.sv and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package bf_pkg;

  // Default image limits, handed to the top-level parameters
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // Fixed field widths
  localparam int unsigned PIX_W     = 8;   // pixel and average
  localparam int unsigned DIM_W     = 11;  // image_width / image_height registers
  localparam int unsigned POS_W     = 10;  // out_row / out_col
  localparam int unsigned CFG_IDX_W = 4;   // register index on the config channel

  // Line store word: {two rows above, row above}
  localparam int unsigned LS_W = 2 * PIX_W;

  // Arithmetic widths
  localparam int unsigned COL_W = 10;  // three-pixel column sum, up to 765
  localparam int unsigned LOW_W = 9;   // two-pixel column sum, up to 510
  localparam int unsigned SUM_W = 12;  // window sum, up to 2295

  // floor(s / 9) == (s * 3641) >> 15, exact for s < 4096
  localparam int unsigned MUL_W      = 12;
  localparam int unsigned DIV9_MUL   = 3641;
  localparam int unsigned DIV9_SHIFT = 15;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

  localparam dim_t DIM_RESET = dim_t'(1024);

endpackage : bf_pkg

`default_nettype wire

// ===== src/bf_if.sv =====
// Valid/ready channel interfaces of the box filter: pixel in, result out, config.
// Depends on bf_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface bf_pix_if;
  import bf_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface : bf_pix_if

interface bf_res_if;
  import bf_pkg::*;
  logic valid;
  logic ready;
  pix_t average;
  pos_t out_row;
  pos_t out_col;
  logic last_of_run;
  logic frame_done;
  modport source (output valid, output average, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input average, input out_row, input out_col,
                  input last_of_run, input frame_done, output ready);
endinterface : bf_res_if

interface bf_cfg_if;
  import bf_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : bf_cfg_if

`default_nettype wire

// ===== src/box_filter_3x3_zero_pad.sv =====
// Top level of the 3x3 zero-padded box mean filter (streaming, raster order).
// Depends on bf_pkg, the channel interfaces in bf_if.sv and bf_ram.
//
//   channel | dir | word                                            | accepted when
//   --------+-----+-------------------------------------------------+---------------
//   cfg_i   | in  | index, data (image_width / image_height)        | valid & ready
//   pix_i   | in  | pixel                                           | valid & ready
//   res_o   | out | average, out_row, out_col, last_of_run, frame_done | valid & ready
//
// One pixel per clock while pix_i.ready is high. The line RAM read is issued at
// accept; stage B does the window update and RAM write-back, and results leave
// through the group and output registers to res_o, one per clock while res_o.ready
// is high. A group of several results holds pix_i.ready low while it drains.
// cfg_i is always ready.
// Reset clears counters, window and control; the line RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_zero_pad #(
  parameter int unsigned MAX_WIDTH  = bf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bf_pkg::DEF_MAX_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bf_cfg_if.sink    cfg_i,
  bf_pix_if.sink    pix_i,
  bf_res_if.source  res_o
);

  import bf_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned NRES   = 4;
  localparam int unsigned PROD_W = SUM_W + MUL_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. A valid write to image_width or image_height restarts the frame.
  // ---------------------------------------------------------------------------
  dim_t width_q, height_q;
  logic cfg_fire, cfg_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_hit     = cfg_fire &&
                       (cfg_i.index == REG_IMAGE_WIDTH || cfg_i.index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Last column / row index, with the register clamped to 1..MAX
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  always_comb begin
    if (width_q == '0) begin
      w_last = '0;
    end else if (width_q > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(width_q - dim_t'(1));
    end
  end

  always_comb begin
    if (height_q == '0) begin
      h_last = '0;
    end else if (height_q > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(height_q - dim_t'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: position counters and line RAM read at accept
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          pix_fire, row_end, frame_end;
  logic          b_fire;

  assign pix_fire  = pix_i.valid && pix_i.ready;
  assign row_end   = (col_q == w_last);
  assign frame_end = (row_q == h_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (pix_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: RAM data back, column sums, window, write-back
  // ---------------------------------------------------------------------------
  logic            b_valid_q;
  pix_t            b_pix_q;
  logic [CW-1:0]   b_col_q;
  logic [RW-1:0]   b_row_q;
  logic            b_end_q, b_last_q;
  logic            fwd_q;        // RAM word is stale: last write hit this address
  logic [LS_W-1:0] fwd_data_q;
  logic [LS_W-1:0] ram_rdata, ram_wdata, line_word;
  logic            c_take;

  assign pix_i.ready = !b_valid_q || b_fire;
  assign b_fire      = b_valid_q && c_take;

  // Row store word layout: [LS_W-1:PIX_W] row r-2, [PIX_W-1:0] row r-1
  assign line_word = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {line_word[PIX_W-1:0], b_pix_q};

  bf_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (b_fire),
    .wr_addr_i (b_col_q),
    .wr_data_i (ram_wdata),
    .rd_en_i   (pix_fire),
    .rd_addr_i (col_q),
    .rd_data_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (pix_i.ready) begin
        b_valid_q <= pix_fire;
        // only a one-column image reads the entry being written this cycle
        fwd_q     <= pix_fire && b_fire && (col_q == b_col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      b_pix_q    <= pix_i.pixel;
      b_col_q    <= col_q;
      b_row_q    <= row_q;
      b_end_q    <= row_end;
      b_last_q   <= frame_end;
      fwd_data_q <= ram_wdata;
    end
  end

  // Zero padding: rows above row 0, columns left of column 0
  logic             r_ge1, r_ge2, c_ge1;
  pix_t             a1, a2;
  logic [COL_W-1:0] col_full, full0_q, full1_q, w_full0, w_full1;
  logic [LOW_W-1:0] col_low, low0_q, low1_q, w_low0, w_low1;
  logic [SUM_W-1:0] sum_v [NRES];
  logic [NRES-1:0]  emit_mask;

  assign r_ge1 = (b_row_q != '0);
  assign r_ge2 = (b_row_q > RW'(1));
  assign c_ge1 = (b_col_q != '0);

  assign a1 = r_ge1 ? line_word[PIX_W-1:0]    : '0;
  assign a2 = r_ge2 ? line_word[LS_W-1:PIX_W] : '0;

  assign col_full = COL_W'(a2) + COL_W'(a1) + COL_W'(b_pix_q);
  assign col_low  = LOW_W'(a1) + LOW_W'(b_pix_q);

  // Window restarts at each row start
  assign w_full0 = c_ge1 ? full0_q : '0;
  assign w_full1 = c_ge1 ? full1_q : '0;
  assign w_low0  = c_ge1 ? low0_q  : '0;
  assign w_low1  = c_ge1 ? low1_q  : '0;

  // Result order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
  assign sum_v[0] = SUM_W'(w_full0) + SUM_W'(w_full1) + SUM_W'(col_full);
  assign sum_v[1] = SUM_W'(w_full1) + SUM_W'(col_full);
  assign sum_v[2] = SUM_W'(w_low0) + SUM_W'(w_low1) + SUM_W'(col_low);
  assign sum_v[3] = SUM_W'(w_low1) + SUM_W'(col_low);

  assign emit_mask = {b_last_q && b_end_q, b_last_q && c_ge1,
                      r_ge1 && b_end_q, r_ge1 && c_ge1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full0_q <= '0;
      full1_q <= '0;
      low0_q  <= '0;
      low1_q  <= '0;
    end else if (b_fire) begin
      full0_q <= w_full1;
      full1_q <= col_full;
      low0_q  <= w_low1;
      low1_q  <= col_low;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: result group, drained one result per cycle, when not stalled by res_o, into the output reg
  // ---------------------------------------------------------------------------
  logic [NRES-1:0]  grp_mask_q, grp_rest;
  logic [SUM_W-1:0] grp_sum_q [NRES];
  logic [CW-1:0]    grp_col_q;
  logic [RW-1:0]    grp_row_q;
  logic [1:0]       sel_idx;
  logic [SUM_W-1:0] sel_sum;
  logic [CW-1:0]    sel_col;
  logic [RW-1:0]    sel_row;
  logic             out_valid_q, out_load, pop;

  always_comb begin
    if (grp_mask_q[0]) begin
      sel_idx = 2'd0;
    end else if (grp_mask_q[1]) begin
      sel_idx = 2'd1;
    end else if (grp_mask_q[2]) begin
      sel_idx = 2'd2;
    end else begin
      sel_idx = 2'd3;
    end
  end

  assign sel_sum  = grp_sum_q[sel_idx];
  assign sel_row  = sel_idx[1] ? grp_row_q : grp_row_q - RW'(1);
  assign sel_col  = sel_idx[0] ? grp_col_q : grp_col_q - CW'(1);
  assign grp_rest = grp_mask_q & ~(NRES'(1) << sel_idx);

  assign out_load = !out_valid_q || res_o.ready;
  assign pop      = (grp_mask_q != '0) && out_load;
  assign c_take   = (grp_mask_q == '0) || (pop && grp_rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_mask_q <= '0;
    end else if (b_fire) begin
      grp_mask_q <= emit_mask;
    end else if (pop) begin
      grp_mask_q <= grp_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      grp_sum_q <= sum_v;
      grp_col_q <= b_col_q;
      grp_row_q <= b_row_q;
    end
  end

  // Divide by nine with a reciprocal multiply, then the output register
  logic [PROD_W-1:0] prod;
  pix_t              out_avg_q;
  pos_t              out_row_q, out_col_q;
  logic              out_last_q, out_done_q;

  assign prod = PROD_W'(sel_sum) * PROD_W'(DIV9_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= (grp_mask_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_avg_q  <= prod[DIV9_SHIFT +: PIX_W];
      out_row_q  <= POS_W'(sel_row);
      out_col_q  <= POS_W'(sel_col);
      out_last_q <= (grp_rest == '0);
      out_done_q <= (sel_idx == 2'd3);  // bottom-right centre of the image
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.average     = out_avg_q;
  assign res_o.out_row     = out_row_q;
  assign res_o.out_col     = out_col_q;
  assign res_o.last_of_run = out_last_q;
  assign res_o.frame_done  = out_done_q;

`ifndef SYNTHESIS
  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last)
    else $error("column counter beyond image width");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last)
    else $error("row counter beyond image height");

  a_fwd_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> b_valid_q)
    else $error("line forward pending with empty stage B");

  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_done) |-> res_o.last_of_run)
    else $error("frame end result not last of its run");

  a_group_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_end_q && b_last_q) |=> grp_mask_q[NRES-1])
    else $error("frame end result missing from group");
`endif

endmodule : box_filter_3x3_zero_pad

`default_nettype wire

// ===== src/bf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule : bf_ram

`default_nettype wire
